// ===== rtl/u8bf_pkg.sv =====
// Shared types and constants for the UTF-8 ill-formed byte filter.
`default_nettype none

package u8bf_pkg;

   localparam int unsigned BurstMax = 4;

   localparam logic [7:0]  ContMask   = 8'hC0;
   localparam logic [7:0]  ContTag    = 8'h80;
   localparam logic [20:0] MinTwo     = 21'h000080;
   localparam logic [20:0] MinThree   = 21'h000800;
   localparam logic [20:0] MinFour    = 21'h010000;
   localparam logic [20:0] MaxCode    = 21'h10FFFF;
   localparam logic [20:0] SurrLow    = 21'h00D800;
   localparam logic [20:0] SurrHigh   = 21'h00DFFF;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       string_end;
      logic       run_last;
   } rsp_type;

   // Results of one input item, lowest byte goes out first.
   typedef struct packed {
      logic [BurstMax-1:0][7:0] bytes;
      logic [2:0]               count;
      logic                     has_byte;
      logic                     string_end;
   } burst_type;

endpackage

`default_nettype wire

// ===== rtl/u8bf_decode.sv =====
// Sequence decoder: holds a pending UTF-8 sequence and builds the result burst.
`default_nettype none

module u8bf_decode (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire u8bf_pkg::req_type in_item,
   output logic                   emit,
   output u8bf_pkg::burst_type    burst
);

   logic [2:0]  exp_len_ff, exp_len_in;
   logic [1:0]  held_cnt_ff, held_cnt_in;
   logic [20:0] code_ff, code_in;
   logic [7:0]  held_ff [3];
   logic [7:0]  held_in [3];

   logic [7:0]  b;
   logic        is_cont;
   logic [20:0] code_next;
   logic [20:0] code_min;
   logic        code_ok;

   always_comb begin
      b         = in_item.in_byte;
      is_cont   = (b & u8bf_pkg::ContMask) == u8bf_pkg::ContTag;
      code_next = {code_ff[14:0], b[5:0]};
      case (exp_len_ff)
         3'd2:    code_min = u8bf_pkg::MinTwo;
         3'd3:    code_min = u8bf_pkg::MinThree;
         default: code_min = u8bf_pkg::MinFour;
      endcase
      code_ok = (code_next >= code_min) && (code_next <= u8bf_pkg::MaxCode) &&
                !((code_next >= u8bf_pkg::SurrLow) && (code_next <= u8bf_pkg::SurrHigh));

      exp_len_in  = exp_len_ff;
      held_cnt_in = held_cnt_ff;
      code_in     = code_ff;
      for (int i = 0; i < 3; i++) begin
         held_in[i] = held_ff[i];
      end
      burst            = '0;
      burst.string_end = in_item.in_last;

      if (exp_len_ff != 3'd0 && is_cont) begin
         if (({1'b0, held_cnt_ff} + 3'd1) >= exp_len_ff) begin
            // sequence complete: release held bytes then this one, if the code point is legal
            if (code_ok) begin
               for (int i = 0; i < 3; i++) begin
                  burst.bytes[i] = (2'(i) < held_cnt_ff) ? held_ff[i] : b;
               end
               burst.bytes[3] = b;
               burst.count    = {1'b0, held_cnt_ff} + 3'd1;
               burst.has_byte = 1'b1;
            end
            exp_len_in  = 3'd0;
            held_cnt_in = 2'd0;
            code_in     = '0;
         end else begin
            for (int i = 0; i < 3; i++) begin
               if (held_cnt_ff == 2'(i)) begin
                  held_in[i] = b;
               end
            end
            held_cnt_in = held_cnt_ff + 2'd1;
            code_in     = code_next;
         end
      end else begin
         // broken or no sequence: decode this byte as a lead
         exp_len_in  = 3'd0;
         held_cnt_in = 2'd0;
         code_in     = '0;
         case (b) inside
            [8'h00:8'h7F]: begin
               burst.bytes[0] = b;
               burst.count    = 3'd1;
               burst.has_byte = 1'b1;
            end
            [8'hC0:8'hDF]: begin
               exp_len_in  = 3'd2;
               code_in     = {16'd0, b[4:0]};
               held_in[0]  = b;
               held_cnt_in = 2'd1;
            end
            [8'hE0:8'hEF]: begin
               exp_len_in  = 3'd3;
               code_in     = {17'd0, b[3:0]};
               held_in[0]  = b;
               held_cnt_in = 2'd1;
            end
            [8'hF0:8'hF7]: begin
               exp_len_in  = 3'd4;
               code_in     = {18'd0, b[2:0]};
               held_in[0]  = b;
               held_cnt_in = 2'd1;
            end
            default: begin
               // lone continuation or invalid lead: drop
            end
         endcase
      end

      if (in_item.in_last) begin
         exp_len_in  = 3'd0;
         held_cnt_in = 2'd0;
         code_in     = '0;
         if (burst.count == 3'd0) begin
            burst.count = 3'd1;
         end
      end

      emit = burst.count != 3'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_len_ff  <= 3'd0;
         held_cnt_ff <= 2'd0;
         code_ff     <= '0;
      end else if (advance) begin
         exp_len_ff  <= exp_len_in;
         held_cnt_ff <= held_cnt_in;
         code_ff     <= code_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            held_ff[i] <= held_in[i];
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/u8bf_burst.sv =====
// Result register: holds one burst and hands it out one byte per item.
`default_nettype none

module u8bf_burst (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire u8bf_pkg::burst_type burst,
   output logic                     can_load,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output u8bf_pkg::rsp_type        rsp_data
);

   logic                                   busy_ff, busy_in;
   logic [2:0]                             rem_ff, rem_in;
   logic [u8bf_pkg::BurstMax-1:0][7:0]     bytes_ff, bytes_in;
   logic                                   has_ff, has_in;
   logic                                   end_ff, end_in;
   logic                                   take;

   always_comb begin
      take     = busy_ff && !rsp_stall;
      can_load = !busy_ff || (take && rem_ff == 3'd1);

      busy_in  = busy_ff;
      rem_in   = rem_ff;
      bytes_in = bytes_ff;
      has_in   = has_ff;
      end_in   = end_ff;
      if (load) begin
         busy_in  = 1'b1;
         rem_in   = burst.count;
         bytes_in = burst.bytes;
         has_in   = burst.has_byte;
         end_in   = burst.string_end;
      end else if (take) begin
         // advance to the next byte of the burst
         busy_in  = rem_ff != 3'd1;
         rem_in   = rem_ff - 3'd1;
         bytes_in = {8'h00, bytes_ff[u8bf_pkg::BurstMax-1:1]};
      end

      rsp_valid           = busy_ff;
      rsp_data.out_byte   = bytes_ff[0];
      rsp_data.has_byte   = has_ff;
      rsp_data.string_end = end_ff;
      rsp_data.run_last   = rem_ff == 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rem_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         rem_ff  <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      has_ff   <= has_in;
      end_ff   <= end_in;
   end

endmodule

`default_nettype wire

// ===== rtl/utf8_ill_formed_byte_filter.sv =====
// Top level of the UTF-8 ill-formed byte filter.
`default_nettype none

// Usage:
//   req channel: one raw byte per item (in_byte), in_last flags the final
//   byte of a string. rsp channel: bytes of well-formed sequences only,
//   with string_end on results of a string's last byte and run_last on the
//   final result of each input item. A last byte that yields nothing gives
//   one bare item with has_byte low.
//   An item is held in the input register, decoded and written to the
//   result register, from which its first result shows on the rsp port.
//   Throughput: one input item per cycle while req_stall is low. A
//   multi-byte sequence drains from the result register one byte per
//   result, and an item that would emit waits in the input register
//   until the last byte of the previous burst is taken.
//   Items that emit nothing (lead and middle bytes) pass on at once.
//   Reset clears the pending sequence and both register valids.
//   When the receiver stalls, the result holds; the stall spreads back to
//   req_stall only once the input register holds an item that must emit.
module utf8_ill_formed_byte_filter (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire u8bf_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output u8bf_pkg::rsp_type      rsp_data
);

   logic                in_valid_ff, in_valid_in;
   u8bf_pkg::req_type   in_item_ff;
   logic                accept;
   logic                move;
   logic                emit;
   logic                can_load;
   u8bf_pkg::burst_type burst;

   u8bf_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .advance (move),
      .in_item (in_item_ff),
      .emit    (emit),
      .burst   (burst)
   );

   u8bf_burst u_burst (
      .clock     (clock),
      .reset     (reset),
      .load      (move && emit),
      .burst     (burst),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always_comb begin
      // advance the held item unless it must emit into a busy result register
      move      = in_valid_ff && (!emit || can_load);
      req_stall = in_valid_ff && !move;
      accept    = req_valid && !req_stall;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (move) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/u8bf_checker.sv =====
// Port-level checks for the UTF-8 ill-formed byte filter, bound to the top level.
`default_nettype none

module u8bf_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire u8bf_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire u8bf_pkg::rsp_type rsp_data
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // no result straight after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a bare item closes a string and carries a zero byte
   a_bare_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_byte |->
         rsp_data.string_end && rsp_data.run_last && rsp_data.out_byte == 8'h00)
      else $error("bare item malformed");

   // only multi-byte sequences span several results
   a_multi_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.run_last |-> rsp_data.has_byte && rsp_data.out_byte[7])
      else $error("run split on a single byte");

   // req_stall is raised only after a sample with req_valid, req_stall or rsp_valid high
   a_req_idle_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> $past(req_valid) || $past(req_stall) || $past(rsp_valid))
      else $error("stall raised with nothing held");

endmodule

bind utf8_ill_formed_byte_filter u8bf_checker u_checker (.*);

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the UTF-8 ill-formed byte filter.
`timescale 1ns / 1ps

module testbench;

   // One stimulus row: the input item, plus an optional expectation typed
   // into the table. Rows marked FromModel take their results from the
   // filter model below instead.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
      logic       from_table;
      logic       fixed_n;
      logic [7:0] fixed_byte;
      logic       fixed_has;
      logic       fixed_end;
   } byte_row_type;

   localparam logic FromTable = 1'b1;
   localparam logic FromModel = 1'b0;

   // Fixed windows, counted in cycles since reset release by each side.
   localparam int unsigned HoldFrom   = 60;    // receiver holds off here
   localparam int unsigned HoldTo     = 160;
   localparam int unsigned SteadyFrom = 250;   // neither side idles here
   localparam int unsigned SteadyTo   = 400;
   localparam int unsigned TargetItems = 330;
   localparam int unsigned DrainCycles = 8;
   localparam int unsigned TimeLimit   = 200_000;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   u8bf_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   u8bf_pkg::rsp_type rsp_data;

   utf8_ill_formed_byte_filter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Filter model state: the pending sequence.
   logic [7:0]  held_byte [0:2];
   logic [2:0]  seq_len;
   logic [1:0]  held_n;
   logic [20:0] code_acc;

   // Results of the last modeled item, in output order.
   u8bf_pkg::rsp_type emit_buf [0:3];
   int unsigned       emit_count;

   byte_row_type      directed_rows [0:22];
   byte_row_type      send_q [$];
   byte_row_type      offer;
   u8bf_pkg::rsp_type filtered_q [$];
   u8bf_pkg::rsp_type want;
   int unsigned       total_items;
   int unsigned       items_taken = 0;
   int unsigned       error_count = 0;
   int unsigned       send_cycles;
   int unsigned       recv_cycles;
   int unsigned       k;

   function automatic void drop_pending();
      seq_len  = 3'd0;
      held_n   = 2'd0;
      code_acc = 21'd0;
   endfunction

   function automatic void push_out(logic [7:0] b, logic has, logic last);
      emit_buf[emit_count] = '{out_byte: b, has_byte: has, string_end: last, run_last: 1'b0};
      emit_count++;
   endfunction

   // Model one accepted byte; fills emit_buf and advances the pending state.
   function automatic void filter_byte(u8bf_pkg::req_type item);
      logic [7:0]  b;
      logic [20:0] least;
      int unsigned i;
      b = item.in_byte;
      emit_count = 0;
      if (seq_len != 0 && (b & u8bf_pkg::ContMask) == u8bf_pkg::ContTag) begin
         code_acc = {code_acc[14:0], b[5:0]};
         if (held_n + 1 >= seq_len) begin
            // Sequence complete: reject overlong, surrogate and out of range.
            least = (seq_len == 3'd2) ? u8bf_pkg::MinTwo :
                    (seq_len == 3'd3) ? u8bf_pkg::MinThree : u8bf_pkg::MinFour;
            if (code_acc >= least && code_acc <= u8bf_pkg::MaxCode &&
                !(code_acc >= u8bf_pkg::SurrLow && code_acc <= u8bf_pkg::SurrHigh)) begin
               for (i = 0; i < held_n; i++)
                  push_out(held_byte[i], 1'b1, item.in_last);
               push_out(b, 1'b1, item.in_last);
            end
            drop_pending();
         end else begin
            held_byte[held_n] = b;
            held_n = held_n + 2'd1;
         end
      end else begin
         // A non-continuation breaks any pending sequence; decode it as a lead.
         drop_pending();
         case (b) inside
            8'b0???????: push_out(b, 1'b1, item.in_last);
            8'b110?????: begin
               seq_len  = 3'd2;
               code_acc = {16'd0, b[4:0]};
            end
            8'b1110????: begin
               seq_len  = 3'd3;
               code_acc = {17'd0, b[3:0]};
            end
            8'b11110???: begin
               seq_len  = 3'd4;
               code_acc = {18'd0, b[2:0]};
            end
            default: ;   // lone continuation or 5+ byte lead
         endcase
         if (seq_len != 0) begin
            held_byte[0] = b;
            held_n = 2'd1;
         end
      end
      if (item.in_last) begin
         drop_pending();
         if (emit_count == 0)
            push_out(8'h00, 1'b0, 1'b1);
      end
      if (emit_count > 0)
         emit_buf[emit_count-1].run_last = 1'b1;
   endfunction

   // Pick a code point that encodes legally in len bytes, edges now and then.
   function automatic logic [20:0] legal_code(int unsigned len);
      logic [20:0] lo, hi, cp;
      int unsigned r;
      case (len)
         1:       begin lo = 21'h0;     hi = 21'h7F;     end
         2:       begin lo = 21'h80;    hi = 21'h7FF;    end
         3:       begin lo = 21'h800;   hi = 21'hFFFF;   end
         default: begin lo = 21'h10000; hi = 21'h10FFFF; end
      endcase
      r = $urandom_range(0, 9);
      if (r == 0)
         cp = lo;
      else if (r == 1)
         cp = hi;
      else
         cp = 21'($urandom_range(lo, hi));
      if (cp >= u8bf_pkg::SurrLow && cp <= u8bf_pkg::SurrHigh)
         cp = cp ^ 21'h004000;
      return cp;
   endfunction

   // Append one random piece of text: mostly well-formed sequences, some
   // ill-formed or cut short, and some raw noise.
   task automatic queue_random_text();
      logic [20:0]     cp;
      logic [3:0][7:0] seq;
      byte_row_type    r;
      int unsigned     len, keep, pick, i;
      pick = $urandom_range(0, 99);
      len  = $urandom_range(1, 4);
      seq  = '0;
      cp   = '0;
      keep = len;
      if (pick < 60) begin
         cp = legal_code(len);
      end else if (pick < 75) begin
         case ($urandom_range(0, 2))
            0: begin
               len = $urandom_range(2, 4);
               cp  = 21'($urandom_range(0, len == 2 ? 'h7F : len == 3 ? 'h7FF : 'hFFFF));
            end
            1: begin
               len = 3;
               cp  = 21'($urandom_range('hD800, 'hDFFF));
            end
            default: begin
               len = 4;
               cp  = 21'($urandom_range('h110000, 'h1FFFFF));
            end
         endcase
         keep = len;
      end else if (pick < 88) begin
         if (len == 1)
            len = 2;
         cp   = legal_code(len);
         keep = $urandom_range(1, len - 1);
      end
      case (len)
         1: seq[0] = {1'b0, cp[6:0]};
         2: begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
         end
         3: begin
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
         end
         default: begin
            seq[0] = {5'b11110, cp[20:18]};
            seq[1] = {2'b10, cp[17:12]};
            seq[2] = {2'b10, cp[11:6]};
            seq[3] = {2'b10, cp[5:0]};
         end
      endcase
      if (pick >= 88) begin
         keep = $urandom_range(1, 3);
         for (i = 0; i < keep; i++)
            seq[i] = 8'($urandom_range(0, 255));
      end
      for (i = 0; i < keep; i++) begin
         r = '0;
         r.in_byte    = seq[i];
         r.in_last    = ($urandom_range(0, 9) == 0);
         r.from_table = FromModel;
         send_q.push_back(r);
      end
   endtask

   task automatic check_field(string field, logic [7:0] expected, logic [7:0] actual);
      if (expected !== actual) begin
         $error("%s: expected %h, actual %h", field, expected, actual);
         error_count++;
      end
   endtask

   // Sender: offer items from send_q, idle at random, hold a stalled item.
   // Model each item at the edge where it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         send_cycles <= 0;
         drop_pending();
      end else begin
         send_cycles <= send_cycles + 1;
         if (req_valid && !req_stall) begin
            filter_byte(u8bf_pkg::req_type'({offer.in_byte, offer.in_last}));
            if (offer.from_table == FromTable) begin
               if (offer.fixed_n)
                  filtered_q.push_back('{out_byte: offer.fixed_byte,
                                         has_byte: offer.fixed_has,
                                         string_end: offer.fixed_end,
                                         run_last: 1'b1});
            end else begin
               for (k = 0; k < emit_count; k++)
                  filtered_q.push_back(emit_buf[k]);
            end
            items_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (send_q.size() != 0 &&
                !((send_cycles < SteadyFrom || send_cycles >= SteadyTo) &&
                  $urandom_range(0, 99) < 25)) begin
               offer = send_q.pop_front();
               req_valid <= 1'b1;
               req_data  <= {offer.in_byte, offer.in_last};
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each accepted result against the oldest expectation,
   // stall at random, and hold off for a long stretch once so the block
   // fills up and stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         recv_cycles <= 0;
      end else begin
         recv_cycles <= recv_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (filtered_q.size() == 0) begin
               $error("unexpected result %h", rsp_data);
               error_count++;
            end else begin
               want = filtered_q.pop_front();
               check_field("out_byte", want.out_byte, rsp_data.out_byte);
               check_field("has_byte", {7'd0, want.has_byte}, {7'd0, rsp_data.has_byte});
               check_field("string_end", {7'd0, want.string_end},
                           {7'd0, rsp_data.string_end});
               check_field("run_last", {7'd0, want.run_last}, {7'd0, rsp_data.run_last});
            end
         end
         if (recv_cycles >= HoldFrom && recv_cycles < HoldTo)
            rsp_stall <= 1'b1;
         else if (recv_cycles >= SteadyFrom && recv_cycles < SteadyTo)
            rsp_stall <= 1'b0;
         else
            rsp_stall <= ($urandom_range(0, 99) < 25);
      end
   end

   initial begin
      // Directed rows: extremes, each sequence length, each rejection rule,
      // a broken sequence and a string that ends mid-sequence.
      directed_rows = '{
         '{8'h00, 1'b0, FromTable, 1'b1, 8'h00, 1'b1, 1'b0},  // lowest ASCII
         '{8'h7F, 1'b1, FromTable, 1'b1, 8'h7F, 1'b1, 1'b1},  // highest ASCII, ends string
         '{8'hFF, 1'b0, FromTable, 1'b0, 8'h00, 1'b0, 1'b0},  // 5+ byte lead: dropped
         '{8'h80, 1'b1, FromTable, 1'b1, 8'h00, 1'b0, 1'b1},  // lone continuation at end
         '{8'hC2, 1'b0, FromModel, 1'b0, 8'h00, 1'b0, 1'b0},  // two-byte U+00A9
         '{8'hA9, 1'b0, FromModel, 1'b0, 8'h00, 1'b0, 1'b0},
         '{8'hC1, 1'b0, FromModel, 1'b0, 8'h00, 1'b0, 1'b0},  // overlong two-byte
         '{8'hBF, 1'b0, FromModel, 1'b0, 8'h00, 1'b0, 1'b0},
         '{8'hED, 1'b0, FromModel, 1'b0, 8'h00, 1'b0, 1'b0},  // surrogate U+D800
         '{8'hA0, 1'b0, FromModel, 1'b0, 8'h00, 1'b0, 1'b0},
         '{8'h80, 1'b0, FromModel, 1'b0, 8'h00, 1'b0, 1'b0},
         '{8'hF4, 1'b0, FromModel, 1'b0, 8'h00, 1'b0, 1'b0},  // above U+10FFFF
         '{8'h90, 1'b0, FromModel, 1'b0, 8'h00, 1'b0, 1'b0},
         '{8'h80, 1'b0, FromModel, 1'b0, 8'h00, 1'b0, 1'b0},
         '{8'h80, 1'b0, FromModel, 1'b0, 8'h00, 1'b0, 1'b0},
         '{8'hF0, 1'b0, FromModel, 1'b0, 8'h00, 1'b0, 1'b0},  // four-byte U+1F600 at end
         '{8'h9F, 1'b0, FromModel, 1'b0, 8'h00, 1'b0, 1'b0},
         '{8'h98, 1'b0, FromModel, 1'b0, 8'h00, 1'b0, 1'b0},
         '{8'h80, 1'b1, FromModel, 1'b0, 8'h00, 1'b0, 1'b0},
         '{8'hE2, 1'b0, FromModel, 1'b0, 8'h00, 1'b0, 1'b0},  // broken by ASCII
         '{8'h82, 1'b0, FromModel, 1'b0, 8'h00, 1'b0, 1'b0},
         '{8'h41, 1'b0, FromModel, 1'b0, 8'h00, 1'b0, 1'b0},
         '{8'hE2, 1'b1, FromTable, 1'b1, 8'h00, 1'b0, 1'b1}   // string ends mid-sequence
      };
      foreach (directed_rows[i])
         send_q.push_back(directed_rows[i]);
      while (send_q.size() < TargetItems)
         queue_random_text();
      total_items = send_q.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Wait for every item to be taken and every result to arrive, then
      // leave a short tail to catch stray results.
      while (items_taken < total_items)
         @(posedge clock);
      while (filtered_q.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #(TimeLimit);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
